>>> design/spm_pkg.sv
`timescale 1ns / 1ps
// Package for the slotted page record manager: payload structs, codes,
// controller states and the command and status structs between the modules.
// Depends on nothing.
package spm_pkg;

  localparam logic [2:0] ACT_INSERT = 3'd0;
  localparam logic [2:0] ACT_WRITE  = 3'd1;
  localparam logic [2:0] ACT_READ   = 3'd2;
  localparam logic [2:0] ACT_UPDATE = 3'd3;
  localparam logic [2:0] ACT_REMOVE = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_INVALID  = 3'd2;
  localparam logic [2:0] ST_DELETED  = 3'd3;
  localparam logic [2:0] ST_RELOCATE = 3'd4;
  localparam logic [2:0] ST_RANGE    = 3'd5;

  localparam logic CFG_HEADER     = 1'b0;
  localparam logic CFG_SLOT_ENTRY = 1'b1;

  localparam logic [12:0] HEADER_RESET     = 13'd24;
  localparam logic [6:0]  SLOT_ENTRY_RESET = 7'd8;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  slot_index;
    logic [12:0] record_size;
    logic [11:0] byte_index;
    logic [7:0]  data_byte;
  } spm_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  result_slot;
    logic [7:0]  read_byte;
    logic [12:0] result_size;
    logic        page_empty;
    logic [12:0] free_bytes;
  } spm_out_t;

  typedef enum logic [1:0] {
    SCAN_FIND_DEL,
    SCAN_ANY_LIVE,
    SCAN_CLEAR,
    SCAN_PICK
  } scan_mode_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_SCAN_INIT,
    OP_SCAN_STEP,
    OP_SET_FULL,
    OP_INS_FIT,
    OP_MV_INIT,
    OP_MV_RD,
    OP_MV_WR,
    OP_MV_END,
    OP_CMP_END,
    OP_SLOT_RD,
    OP_SLOT_EV,
    OP_PG_RD_EV,
    OP_RM_DONE,
    OP_LOAD_OUT
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_INS_SCAN,
    S_INS_DEC,
    S_CLR,
    S_PICK,
    S_MV_CHK,
    S_MV_WR,
    S_FIT,
    S_SLOT_EV,
    S_RD_EV,
    S_RM_SCAN,
    S_FIN
  } spm_state_t;

  typedef struct packed {
    dp_op_t     op;
    scan_mode_t mode;
  } spm_cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       scan_done;
    logic       reuse_ok;
    logic       dir_full;
    logic       gap_ok;
    logic       best_ok;
    logic       mv_left;
    logic       slot_bad;
    logic       rd_go;
    logic       out_free;
  } spm_stat_t;

endpackage

>>> design/spm_datapath.sv
`timescale 1ns / 1ps
// Datapath of the slotted page record manager: page and slot directory
// memories, page bookkeeping registers, directory scanner and result register.
// Depends on spm_pkg.
module spm_datapath #(
  parameter int PAGE_BYTES = 4096,
  parameter int MAX_SLOTS  = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  spm_pkg::spm_in_t  in_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [12:0]       cfg_data,
  input  spm_pkg::spm_cmd_t cmd,
  output spm_pkg::spm_stat_t stat,
  input  logic              out_ready,
  output logic              out_valid,
  output spm_pkg::spm_out_t out_data
);
  import spm_pkg::*;

  localparam int PA_W  = $clog2(PAGE_BYTES);
  localparam int SI_W  = $clog2(MAX_SLOTS);
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int POS_W = ($clog2(PAGE_BYTES + 1) > 13) ? $clog2(PAGE_BYTES + 1) : 13;
  localparam int AW    = POS_W + 1;
  localparam int SW    = (CNT_W > 8) ? CNT_W : 8;

  logic [7:0]       page_mem [PAGE_BYTES];
  logic [POS_W-1:0] off_mem  [MAX_SLOTS];
  logic [12:0]      len_mem  [MAX_SLOTS];
  logic             del_mem  [MAX_SLOTS];
  logic             mark_mem [MAX_SLOTS];

  logic [7:0]       pg_q;
  logic [POS_W-1:0] off_q;
  logic [12:0]      len_q;
  logic             del_q;
  logic             mark_q;

  spm_in_t          item_r;
  logic [6:0]       seb_r;
  logic [CNT_W-1:0] count_r;
  logic [POS_W-1:0] dir_r;
  logic [POS_W-1:0] ras_r;
  logic [POS_W-1:0] dest_r;
  scan_mode_t       mode_r;
  logic [CNT_W-1:0] idx_r;
  logic             pend_r;
  logic [SI_W-1:0]  pidx_r;
  logic             reuse_ok_r;
  logic [SI_W-1:0]  reuse_idx_r;
  logic             live_r;
  logic             best_ok_r;
  logic [SI_W-1:0]  best_idx_r;
  logic [POS_W-1:0] best_off_r;
  logic [12:0]      best_len_r;
  logic [12:0]      bcnt_r;
  logic             src_ok_r;
  logic [2:0]       res_status_r;
  logic [7:0]       res_slot_r;
  logic [7:0]       res_byte_r;
  logic [12:0]      res_size_r;
  logic             res_empty_r;
  logic             out_valid_r;
  spm_out_t         out_data_r;

  logic [POS_W-1:0] gap;
  logic [AW-1:0]    needed;
  logic             gap_ok;
  logic             step_go;
  logic             slot_bad;
  logic [SI_W-1:0]  slot_a;
  logic [AW-1:0]    rec_addr;
  logic             range_bad;
  logic [AW-1:0]    mv_src;
  logic [AW-1:0]    mv_dst;
  logic [12:0]      lenp;
  logic [12:0]      fb_sat;
  logic [SI_W-1:0]  ins_slot;
  logic [POS_W-1:0] new_ras;

  logic             sl_re;
  logic [SI_W-1:0]  sl_ra;
  logic [SI_W-1:0]  sl_wa;
  logic             off_we, len_we, del_we, mark_we;
  logic [POS_W-1:0] off_wd;
  logic [12:0]      len_wd;
  logic             del_wd, mark_wd;
  logic             pg_re, pg_we;
  logic [PA_W-1:0]  pg_ra, pg_wa;
  logic [7:0]       pg_wd;

  assign gap       = (ras_r > dir_r) ? (ras_r - dir_r) : '0;
  assign needed    = AW'(item_r.record_size) + (reuse_ok_r ? AW'(0) : AW'(seb_r));
  assign gap_ok    = AW'(gap) >= needed;
  assign step_go   = idx_r < count_r;
  assign slot_bad  = SW'(item_r.slot_index) >= SW'(count_r);
  assign slot_a    = SI_W'(item_r.slot_index);
  assign rec_addr  = AW'(off_q) + AW'(item_r.byte_index);
  assign range_bad = (AW'(item_r.byte_index) >= AW'(len_q)) || (rec_addr >= AW'(PAGE_BYTES));
  assign mv_src    = AW'(best_off_r) + AW'(bcnt_r) - AW'(1);
  assign mv_dst    = AW'(dest_r) + AW'(bcnt_r) - AW'(1);
  assign lenp      = (AW'(best_len_r) > AW'(dest_r)) ? 13'(dest_r) : best_len_r;
  assign fb_sat    = (AW'(gap) > AW'(8191)) ? 13'h1FFF : 13'(gap);
  assign ins_slot  = reuse_ok_r ? reuse_idx_r : SI_W'(count_r);
  assign new_ras   = ras_r - POS_W'(item_r.record_size);

  assign stat.action    = item_r.action;
  assign stat.scan_done = !step_go && !pend_r;
  assign stat.reuse_ok  = reuse_ok_r;
  assign stat.dir_full  = !reuse_ok_r && (count_r == CNT_W'(MAX_SLOTS));
  assign stat.gap_ok    = gap_ok;
  assign stat.best_ok   = best_ok_r;
  assign stat.mv_left   = bcnt_r != 13'd0;
  assign stat.slot_bad  = slot_bad;
  assign stat.rd_go     = (item_r.action == ACT_READ) && !del_q && !range_bad;
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    sl_re   = 1'b0;
    sl_ra   = slot_a;
    sl_wa   = slot_a;
    off_we  = 1'b0;
    len_we  = 1'b0;
    del_we  = 1'b0;
    mark_we = 1'b0;
    off_wd  = new_ras;
    len_wd  = item_r.record_size;
    del_wd  = 1'b0;
    mark_wd = 1'b0;
    pg_re   = 1'b0;
    pg_we   = 1'b0;
    pg_ra   = PA_W'(rec_addr);
    pg_wa   = PA_W'(rec_addr);
    pg_wd   = item_r.data_byte;
    case (cmd.op)
      OP_SCAN_STEP: begin
        if (step_go) begin
          if (mode_r == SCAN_CLEAR) begin
            mark_we = 1'b1;
            sl_wa   = SI_W'(idx_r);
          end else begin
            sl_re = 1'b1;
            sl_ra = SI_W'(idx_r);
          end
        end
      end
      OP_SLOT_RD: begin
        sl_re = 1'b1;
      end
      OP_SLOT_EV: begin
        if (item_r.action == ACT_REMOVE) begin
          del_we = 1'b1;
          del_wd = 1'b1;
        end else if (!del_q) begin
          if (item_r.action == ACT_UPDATE) begin
            len_we = item_r.record_size <= len_q;
          end else if (!range_bad) begin
            pg_we = item_r.action == ACT_WRITE;
            pg_re = item_r.action == ACT_READ;
          end
        end
      end
      OP_MV_RD: begin
        pg_re = 1'b1;
        pg_ra = PA_W'(mv_src);
      end
      OP_MV_WR: begin
        pg_we = src_ok_r;
        pg_wa = PA_W'(mv_dst);
        pg_wd = pg_q;
      end
      OP_MV_END: begin
        sl_wa   = best_idx_r;
        off_we  = 1'b1;
        off_wd  = dest_r;
        mark_we = 1'b1;
        mark_wd = 1'b1;
      end
      OP_INS_FIT: begin
        sl_wa  = ins_slot;
        off_we = gap_ok;
        len_we = gap_ok;
        del_we = gap_ok;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pg_we) begin
      page_mem[pg_wa] <= pg_wd;
    end
    if (pg_re) begin
      pg_q <= page_mem[pg_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (off_we) begin
      off_mem[sl_wa] <= off_wd;
    end
    if (len_we) begin
      len_mem[sl_wa] <= len_wd;
    end
    if (del_we) begin
      del_mem[sl_wa] <= del_wd;
    end
    if (mark_we) begin
      mark_mem[sl_wa] <= mark_wd;
    end
    if (sl_re) begin
      off_q  <= off_mem[sl_ra];
      len_q  <= len_mem[sl_ra];
      del_q  <= del_mem[sl_ra];
      mark_q <= mark_mem[sl_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seb_r       <= SLOT_ENTRY_RESET;
      count_r     <= '0;
      dir_r       <= POS_W'(HEADER_RESET);
      ras_r       <= POS_W'(PAGE_BYTES);
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      if (cmd.op == OP_LOAD_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        OP_SCAN_INIT, OP_MV_END, OP_SLOT_EV: begin
          pend_r <= 1'b0;
        end
        OP_SCAN_STEP: begin
          pend_r <= step_go && (mode_r != SCAN_CLEAR);
        end
        OP_CMP_END: begin
          ras_r <= dest_r;
        end
        OP_INS_FIT: begin
          if (gap_ok) begin
            ras_r <= new_ras;
            if (!reuse_ok_r) begin
              count_r <= count_r + CNT_W'(1);
              dir_r   <= dir_r + POS_W'(seb_r);
            end
          end
        end
        default: begin
        end
      endcase
      if (cfg_we) begin
        case (cfg_index)
          CFG_HEADER: begin
            if (count_r == '0) begin
              dir_r <= POS_W'(cfg_data);
            end
          end
          CFG_SLOT_ENTRY: begin
            seb_r <= cfg_data[6:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        item_r       <= in_data;
        res_status_r <= ST_OK;
        res_slot_r   <= '0;
        res_byte_r   <= '0;
        res_size_r   <= '0;
        res_empty_r  <= 1'b0;
      end
      OP_SCAN_INIT: begin
        mode_r <= cmd.mode;
        idx_r  <= '0;
        case (cmd.mode)
          SCAN_FIND_DEL: reuse_ok_r <= 1'b0;
          SCAN_ANY_LIVE: live_r     <= 1'b0;
          SCAN_PICK:     best_ok_r  <= 1'b0;
          SCAN_CLEAR:    dest_r     <= POS_W'(PAGE_BYTES);
          default: begin
          end
        endcase
      end
      OP_SCAN_STEP: begin
        if (step_go) begin
          pidx_r <= SI_W'(idx_r);
          idx_r  <= idx_r + CNT_W'(1);
        end
        if (pend_r) begin
          case (mode_r)
            SCAN_FIND_DEL: begin
              if (del_q && !reuse_ok_r) begin
                reuse_ok_r  <= 1'b1;
                reuse_idx_r <= pidx_r;
              end
            end
            SCAN_ANY_LIVE: begin
              if (!del_q) begin
                live_r <= 1'b1;
              end
            end
            SCAN_PICK: begin
              if (!del_q && !mark_q && (!best_ok_r || off_q > best_off_r)) begin
                best_ok_r  <= 1'b1;
                best_idx_r <= pidx_r;
                best_off_r <= off_q;
                best_len_r <= len_q;
              end
            end
            default: begin
            end
          endcase
        end
      end
      OP_MV_INIT: begin
        dest_r <= dest_r - POS_W'(lenp);
        bcnt_r <= lenp;
      end
      OP_MV_RD: begin
        src_ok_r <= mv_src < AW'(PAGE_BYTES);
      end
      OP_MV_WR: begin
        bcnt_r <= bcnt_r - 13'd1;
      end
      OP_MV_END: begin
        mode_r    <= SCAN_PICK;
        idx_r     <= '0;
        best_ok_r <= 1'b0;
      end
      OP_SET_FULL: begin
        res_status_r <= ST_FULL;
      end
      OP_INS_FIT: begin
        if (gap_ok) begin
          res_slot_r <= 8'(ins_slot);
          res_size_r <= item_r.record_size;
        end else begin
          res_status_r <= ST_FULL;
        end
      end
      OP_SLOT_RD: begin
        if (slot_bad) begin
          res_status_r <= ST_INVALID;
        end
      end
      OP_SLOT_EV: begin
        res_size_r <= len_q;
        if (item_r.action == ACT_REMOVE) begin
          mode_r <= SCAN_ANY_LIVE;
          idx_r  <= '0;
          live_r <= 1'b0;
        end else if (del_q) begin
          res_status_r <= ST_DELETED;
        end else if (item_r.action == ACT_UPDATE) begin
          if (item_r.record_size <= len_q) begin
            res_size_r <= item_r.record_size;
          end else begin
            res_status_r <= ST_RELOCATE;
          end
        end else if (range_bad) begin
          res_status_r <= ST_RANGE;
        end
      end
      OP_PG_RD_EV: begin
        res_byte_r <= pg_q;
      end
      OP_RM_DONE: begin
        res_empty_r <= !live_r;
      end
      OP_LOAD_OUT: begin
        out_data_r.status      <= res_status_r;
        out_data_r.result_slot <= res_slot_r;
        out_data_r.read_byte   <= res_byte_r;
        out_data_r.result_size <= res_size_r;
        out_data_r.page_empty  <= res_empty_r;
        out_data_r.free_bytes  <= fb_sat;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> design/spm_controller.sv
`timescale 1ns / 1ps
// Controller state machine of the slotted page record manager. It sequences
// the datapath through commands and follows its status. Depends on spm_pkg.
module spm_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  spm_pkg::spm_stat_t stat,
  output spm_pkg::spm_cmd_t  cmd
);
  import spm_pkg::*;

  spm_state_t state_r;
  spm_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    cmd.mode  = SCAN_FIND_DEL;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_CAPTURE;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.action == ACT_INSERT) begin
          cmd.op    = OP_SCAN_INIT;
          cmd.mode  = SCAN_FIND_DEL;
          state_nxt = S_INS_SCAN;
        end else if (stat.action inside {ACT_WRITE, ACT_READ, ACT_UPDATE, ACT_REMOVE}) begin
          cmd.op    = OP_SLOT_RD;
          state_nxt = stat.slot_bad ? S_FIN : S_SLOT_EV;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_INS_SCAN: begin
        if (stat.scan_done) begin
          state_nxt = S_INS_DEC;
        end else begin
          cmd.op = OP_SCAN_STEP;
        end
      end
      S_INS_DEC: begin
        if (stat.dir_full) begin
          cmd.op    = OP_SET_FULL;
          state_nxt = S_FIN;
        end else if (stat.reuse_ok && !stat.gap_ok) begin
          cmd.op    = OP_SCAN_INIT;
          cmd.mode  = SCAN_CLEAR;
          state_nxt = S_CLR;
        end else begin
          cmd.op    = OP_INS_FIT;
          state_nxt = S_FIN;
        end
      end
      S_CLR: begin
        if (stat.scan_done) begin
          cmd.op    = OP_SCAN_INIT;
          cmd.mode  = SCAN_PICK;
          state_nxt = S_PICK;
        end else begin
          cmd.op = OP_SCAN_STEP;
        end
      end
      S_PICK: begin
        if (!stat.scan_done) begin
          cmd.op = OP_SCAN_STEP;
        end else if (stat.best_ok) begin
          cmd.op    = OP_MV_INIT;
          state_nxt = S_MV_CHK;
        end else begin
          cmd.op    = OP_CMP_END;
          state_nxt = S_FIT;
        end
      end
      S_MV_CHK: begin
        if (stat.mv_left) begin
          cmd.op    = OP_MV_RD;
          state_nxt = S_MV_WR;
        end else begin
          cmd.op    = OP_MV_END;
          state_nxt = S_PICK;
        end
      end
      S_MV_WR: begin
        cmd.op    = OP_MV_WR;
        state_nxt = S_MV_CHK;
      end
      S_FIT: begin
        cmd.op    = OP_INS_FIT;
        state_nxt = S_FIN;
      end
      S_SLOT_EV: begin
        cmd.op = OP_SLOT_EV;
        if (stat.action == ACT_REMOVE) begin
          state_nxt = S_RM_SCAN;
        end else if (stat.rd_go) begin
          state_nxt = S_RD_EV;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_RD_EV: begin
        cmd.op    = OP_PG_RD_EV;
        state_nxt = S_FIN;
      end
      S_RM_SCAN: begin
        if (stat.scan_done) begin
          cmd.op    = OP_RM_DONE;
          state_nxt = S_FIN;
        end else begin
          cmd.op = OP_SCAN_STEP;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.op    = OP_LOAD_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> design/slotted_page_record_manager_top.sv
`timescale 1ns / 1ps
// Top level of the slotted page record manager: controller and datapath.
// Depends on spm_pkg, spm_controller and spm_datapath.
//
//   Channel  Handshake             Payload
//   in       in_valid / in_ready   in_data (spm_in_t)
//   out      out_valid / out_ready out_data (spm_out_t)
//   cfg      cfg_we                cfg_index, cfg_data
//
// One transaction at a time; each result is loaded into the output register
// before the next item is accepted. An insert that reuses a deleted slot but
// finds too small a gap compacts first: a pass clears the move marks, then each
// live record, highest offset first, is copied byte by byte towards the page end.
// Reset is synchronous and needs no clearing pass. A result waits in the output
// register until it is taken.
module slotted_page_record_manager_top #(
  parameter int PAGE_BYTES = 4096,
  parameter int MAX_SLOTS  = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  spm_pkg::spm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output spm_pkg::spm_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [12:0]       cfg_data
);
  import spm_pkg::*;

  spm_cmd_t  cmd;
  spm_stat_t stat;

  spm_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  spm_datapath #(
    .PAGE_BYTES (PAGE_BYTES),
    .MAX_SLOTS  (MAX_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> design/spm_checker.sv
`timescale 1ns / 1ps
// Port checker for the slotted page record manager, bound to the top level.
// Depends on spm_pkg and slotted_page_record_manager_top.
module spm_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input spm_pkg::spm_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input spm_pkg::spm_out_t out_data,
  input logic              cfg_we,
  input logic              cfg_index,
  input logic [12:0]       cfg_data
);
  import spm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Result changed or dropped while stalled.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Second transaction taken before the first finished.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_RANGE)
    else $error("Undefined status code.");

  a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.result_slot == 8'd0 &&
      out_data.read_byte == 8'd0)
    else $error("Failed transaction reports a slot or a byte.");

endmodule

bind slotted_page_record_manager_top spm_checker u_spm_checker (.*);

>>> dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for slotted_page_record_manager_top: directed and
// random page actions are checked against a built-in page and slot predictor.
// Depends on spm_pkg and the design files under design/.
module tb;
  import spm_pkg::*;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  spm_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  spm_out_t out_data;
  logic     cfg_we = 1'b0;
  logic     cfg_index = CFG_HEADER;
  logic [12:0] cfg_data = '0;

  slotted_page_record_manager_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  localparam int PAGE = 4096;
  localparam int SLOTS = 256;

  logic [7:0]  page_mem [PAGE];
  bit          page_known [PAGE];
  int unsigned slot_off [SLOTS];
  int unsigned slot_len [SLOTS];
  bit          slot_del [SLOTS];
  bit          slot_moved [SLOTS];
  int unsigned n_slots = 0;
  int unsigned dir_end = HEADER_RESET;
  int unsigned area_start = PAGE;
  int unsigned header_reg = HEADER_RESET;
  int unsigned entry_reg = SLOT_ENTRY_RESET;

  spm_out_t pending_results[$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_left = 0;
  int fill_slot = -1;
  int fill_next = 0;

  function automatic int unsigned page_gap();
    return (area_start > dir_end) ? area_start - dir_end : 0;
  endfunction

  function automatic int first_deleted();
    for (int i = 0; i < n_slots; i++)
      if (slot_del[i]) return i;
    return -1;
  endfunction

  function automatic int first_live();
    for (int i = 0; i < n_slots; i++)
      if (!slot_del[i]) return i;
    return -1;
  endfunction

  function automatic void slide_live_records();
    int unsigned dest;
    int pick;
    int unsigned len;
    dest = PAGE;
    foreach (slot_moved[i]) slot_moved[i] = 1'b0;
    forever begin
      pick = -1;
      for (int i = 0; i < n_slots; i++) begin
        if (slot_del[i] || slot_moved[i]) continue;
        if (pick < 0 || slot_off[i] > slot_off[pick]) pick = i;
      end
      if (pick < 0) break;
      slot_moved[pick] = 1'b1;
      len = (slot_len[pick] > dest) ? dest : slot_len[pick];
      dest -= len;
      for (int b = len; b > 0; b--) begin
        if (slot_off[pick] + b - 1 < PAGE && dest + b - 1 < PAGE) begin
          page_mem[dest + b - 1] = page_mem[slot_off[pick] + b - 1];
          page_known[dest + b - 1] = page_known[slot_off[pick] + b - 1];
        end
      end
      slot_off[pick] = dest;
    end
    area_start = dest;
  endfunction

  function automatic spm_out_t page_action(spm_in_t it);
    spm_out_t r;
    int reuse;
    int unsigned needed, s, addr, fb;
    r = '0;
    if (it.action == ACT_INSERT) begin
      reuse = first_deleted();
      needed = it.record_size + ((reuse < 0) ? entry_reg : 0);
      if (reuse < 0 && n_slots >= SLOTS) begin
        r.status = ST_FULL;
      end else begin
        if (page_gap() < needed && reuse >= 0) slide_live_records();
        if (page_gap() < needed) begin
          r.status = ST_FULL;
        end else begin
          area_start -= it.record_size;
          if (reuse >= 0) begin
            s = reuse;
          end else begin
            s = n_slots;
            n_slots++;
            dir_end += entry_reg;
          end
          slot_off[s] = area_start;
          slot_len[s] = it.record_size;
          slot_del[s] = 1'b0;
          r.status = ST_OK;
          r.result_slot = s[7:0];
          r.result_size = it.record_size;
        end
      end
    end else if (it.action >= ACT_WRITE && it.action <= ACT_REMOVE) begin
      s = it.slot_index;
      if (s >= n_slots) begin
        r.status = ST_INVALID;
      end else if (it.action == ACT_REMOVE) begin
        slot_del[s] = 1'b1;
        r.result_size = 13'(slot_len[s]);
        r.page_empty = (first_live() < 0);
      end else if (slot_del[s]) begin
        r.status = ST_DELETED;
        r.result_size = 13'(slot_len[s]);
      end else if (it.action == ACT_UPDATE) begin
        if (it.record_size <= slot_len[s]) slot_len[s] = it.record_size;
        else r.status = ST_RELOCATE;
        r.result_size = 13'(slot_len[s]);
      end else begin
        addr = slot_off[s] + it.byte_index;
        r.result_size = 13'(slot_len[s]);
        if (it.byte_index >= slot_len[s] || addr >= PAGE) begin
          r.status = ST_RANGE;
        end else if (it.action == ACT_WRITE) begin
          page_mem[addr] = it.data_byte;
          page_known[addr] = 1'b1;
        end else begin
          r.read_byte = page_mem[addr];
        end
      end
    end
    fb = page_gap();
    r.free_bytes = (fb > 8191) ? 13'h1FFF : fb[12:0];
    return r;
  endfunction

  function automatic spm_in_t mk(logic [2:0] act, int slot, int size, int bidx, int dat);
    spm_in_t it;
    it.action = act;
    it.slot_index = slot[7:0];
    it.record_size = size[12:0];
    it.byte_index = bidx[11:0];
    it.data_byte = dat[7:0];
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(spm_in_t it);
    spm_out_t r;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    r = page_action(it);
    pending_results.insert(pending_results.size(), r);
    if (it.action == ACT_INSERT && r.status == ST_OK && it.record_size > 0 &&
        it.record_size <= 12) begin
      fill_slot = r.result_slot;
      fill_next = 0;
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[12:0];
    if (idx == CFG_HEADER) begin
      header_reg = val;
      if (n_slots == 0) dir_end = header_reg;
    end else begin
      entry_reg = val & 32'h7F;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  task automatic report(string field, int exp_v, int act_v);
    $display("%0t: mismatch in %s: expected %0d, actual %0d", $realtime, field, exp_v,
             act_v);
    errors++;
  endtask

  always @(posedge clk) begin
    spm_out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual %p", $realtime,
                 out_data);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_data.status !== e.status) report("status", e.status, out_data.status);
        if (out_data.result_slot !== e.result_slot)
          report("result_slot", e.result_slot, out_data.result_slot);
        if (out_data.read_byte !== e.read_byte)
          report("read_byte", e.read_byte, out_data.read_byte);
        if (out_data.result_size !== e.result_size)
          report("result_size", e.result_size, out_data.result_size);
        if (out_data.page_empty !== e.page_empty)
          report("page_empty", e.page_empty, out_data.page_empty);
        if (out_data.free_bytes !== e.free_bytes)
          report("free_bytes", e.free_bytes, out_data.free_bytes);
      end
    end
  end

  function automatic int any_slot();
    if ($urandom_range(0, 9) == 0 || n_slots == 0) return $urandom_range(0, 255);
    return $urandom_range(0, n_slots - 1);
  endfunction

  function automatic spm_in_t next_random_item();
    int r, s, b;
    r = $urandom_range(0, 99);
    if (fill_slot >= 0 && !slot_del[fill_slot] && fill_next < slot_len[fill_slot] &&
        r < 80) begin
      fill_next++;
      return mk(ACT_WRITE, fill_slot, 0, fill_next - 1, $urandom_range(0, 255));
    end
    if (r < 3) return mk(3'($urandom_range(5, 7)), $urandom_range(0, 255),
                         $urandom_range(0, 8191), $urandom_range(0, 4095),
                         $urandom_range(0, 255));
    if (r < 25) begin
      if (first_deleted() < 0 && n_slots >= 160)
        return mk(ACT_REMOVE, any_slot(), 0, 0, 0);
      r = $urandom_range(0, 99);
      s = (r < 85) ? $urandom_range(0, 16) :
          (r < 95) ? $urandom_range(17, 200) : $urandom_range(0, 4096);
      return mk(ACT_INSERT, $urandom_range(0, 255), s, $urandom_range(0, 4095), 0);
    end
    if (r < 75 && r >= 50) begin
      for (int t = 0; t < 8; t++) begin
        if (n_slots == 0) break;
        s = $urandom_range(0, n_slots - 1);
        if (slot_del[s] || slot_len[s] == 0) continue;
        b = $urandom_range(0, slot_len[s] - 1);
        if (slot_off[s] + b < PAGE && page_known[slot_off[s] + b])
          return mk(ACT_READ, s, $urandom_range(0, 8191), b, $urandom_range(0, 255));
      end
      s = any_slot();
      return mk(ACT_READ, s, 0, 4095, 0);
    end
    if (r < 75) begin
      s = any_slot();
      b = (s < n_slots && slot_len[s] > 0 && $urandom_range(0, 9) > 0) ?
          $urandom_range(0, slot_len[s] - 1) : $urandom_range(0, 4095);
      return mk(ACT_WRITE, s, $urandom_range(0, 8191), b, $urandom_range(0, 255));
    end
    s = any_slot();
    if (r < 85) begin
      b = (s < n_slots && $urandom_range(0, 3) > 0) ? $urandom_range(0, slot_len[s] + 2)
                                                   : $urandom_range(0, 4096);
      return mk(ACT_UPDATE, s, b, $urandom_range(0, 4095), 0);
    end
    return mk(ACT_REMOVE, s, $urandom_range(0, 8191), $urandom_range(0, 4095), 0);
  endfunction

  task automatic test_directed();
    write_reg(CFG_HEADER, 4096);
    send_item(mk(ACT_INSERT, 0, 0, 0, 0));
    wait_idle();
    write_reg(CFG_HEADER, 0);
    write_reg(CFG_SLOT_ENTRY, 1);
    send_item(mk(ACT_INSERT, 0, 4096, 0, 0));
    send_item(mk(ACT_INSERT, 0, 4095, 0, 0));
    send_item(mk(ACT_WRITE, 0, 0, 0, 8'hA5));
    send_item(mk(ACT_WRITE, 0, 0, 4094, 8'h5A));
    send_item(mk(ACT_READ, 0, 0, 0, 0));
    send_item(mk(ACT_READ, 0, 0, 4094, 0));
    send_item(mk(ACT_WRITE, 0, 0, 4095, 8'hFF));
    send_item(mk(ACT_READ, 0, 0, 4095, 0));
    send_item(mk(ACT_UPDATE, 0, 4096, 0, 0));
    send_item(mk(ACT_UPDATE, 0, 4094, 0, 0));
    for (int a = 5; a <= 7; a++)
      send_item(mk(3'(a), 255, 8191, 4095, 255));
    send_item(mk(ACT_WRITE, 255, 0, 0, 0));
    send_item(mk(ACT_REMOVE, 0, 0, 0, 0));
    send_item(mk(ACT_REMOVE, 0, 0, 0, 0));
    send_item(mk(ACT_WRITE, 0, 0, 0, 1));
    send_item(mk(ACT_READ, 0, 0, 0, 0));
    send_item(mk(ACT_UPDATE, 0, 1, 0, 0));
    send_item(mk(ACT_INSERT, 0, 100, 0, 0));
    send_item(mk(ACT_INSERT, 0, 0, 0, 0));
    send_item(mk(ACT_INSERT, 0, 0, 0, 0));
    send_item(mk(ACT_INSERT, 0, 3, 0, 0));
    for (int b = 0; b < 3; b++) send_item(mk(ACT_WRITE, 3, 0, b, 8'h30 + b));
    send_item(mk(ACT_REMOVE, 0, 0, 0, 0));
    send_item(mk(ACT_INSERT, 0, page_gap() + 50, 0, 0));
    send_item(mk(ACT_READ, 3, 0, 2, 0));
    wait_idle();
  endtask

  task automatic test_random(int count, int s_idle, int r_idle);
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int n = 0; n < count; n++) send_item(next_random_item());
    wait_idle();
  endtask

  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 0;
    @(posedge clk);
    hold_left = 400;
    @(negedge clk);
    for (int n = 0; n < 40; n++) send_item(next_random_item());
    wait_idle();
  endtask

  task automatic test_full_directory();
    int unsigned g;
    send_idle = 0;
    recv_idle = 30;
    write_reg(CFG_SLOT_ENTRY, 1);
    for (int s = 0; s < n_slots; s++) send_item(mk(ACT_REMOVE, s, 0, 0, 0));
    g = page_gap() + 1;
    if (n_slots > 0 && g <= 4096) begin
      send_item(mk(ACT_INSERT, 0, g, 0, 0));
      send_item(mk(ACT_REMOVE, 0, 0, 0, 0));
    end
    for (int n = 0; n < 300; n++) begin
      send_item(mk(ACT_INSERT, 0, 0, 0, 0));
      if (n_slots == SLOTS && first_deleted() < 0) begin
        send_item(mk(ACT_INSERT, 0, 0, 0, 0));
        break;
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    write_reg(CFG_SLOT_ENTRY, 64);
    write_reg(CFG_HEADER, 4096);
    test_random(200, 14, 84);
    write_reg(CFG_SLOT_ENTRY, 1);
    write_reg(CFG_HEADER, 0);
    test_random(200, 84, 14);
    write_reg(CFG_SLOT_ENTRY, 8);
    write_reg(CFG_HEADER, 24);
    test_random(250, 0, 0);
    test_backpressure();
    test_full_directory();
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5s;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
